>>> rtl/phm_pkg.sv
// Shared constants, types and width helpers for the projective pixel-to-world map.
`default_nettype none
package phm_pkg;

	localparam int PIXEL_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int PROJ_FRAC      = 30;
	localparam int W_EPS_Q30      = 1073;
	localparam int QUOT_BITS      = 33;
	localparam int CFG_IDX_BITS   = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ROW_X  = 3'd0,
		CFG_ROW_Y  = 3'd1,
		CFG_ROW_W  = 3'd2,
		CFG_OFFS_X = 3'd3,
		CFG_OFFS_Y = 3'd4,
		CFG_OFFS_W = 3'd5
	} cfg_reg_e;

	// Control carried along with each quotient word
	typedef struct packed {
		logic valid;
		logic ok;
		logic neg;
	} phm_ctl_t;

	// Width of the exact x_h, y_h and w_h sums
	function automatic int sum_width(input int p, input int f);
		int a;
		int b;
		a = 35 + p;
		b = 64 - f;
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

>>> rtl/projective_pixel_to_world_map_top.sv
// Top level: maps pixel (u, v) through a configured 3x3 homography to world (x, y).
// Each input word (u in the low PIXEL_BITS, v above) yields one output word with
// world_x, world_y in signed fixed point with FRAC_BITS fraction bits and a valid
// flag in tuser. A word is taken every cycle unless output waits. The map has three
// front stages (products, sums, magnitudes), then two dividers side by side that
// retire one quotient bit per stage (an entry stage, 33 bit stages, a sign stage),
// then the output register. The pipeline freezes as a whole while the output word
// waits. Points whose denominator magnitude is not above about 1e-6, or whose
// quotient leaves the signed 32-bit range, come out as 0,0 with the flag low. The
// user must write configuration registers on cfg by index while idle; not enforced.
`default_nettype none
module projective_pixel_to_world_map_top #(
	parameter int PIXEL_BITS = phm_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = phm_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// pixel_u, pixel_v, zero padding
	input  wire logic [((2*PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// world_x, world_y
	output logic [63:0]                                m_axis_tdata,
	// point_valid
	output logic                                       m_axis_tuser,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [phm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [63:0]                           cfg_data
);
	import phm_pkg::*;

	localparam int SW = sum_width(PIXEL_BITS, FRAC_BITS);
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

	logic [63:0]    row_x_q, row_y_q, row_w_q;
	logic [31:0]    offs_x_q, offs_y_q, offs_w_q;
	logic           en;
	phm_ctl_t       fx_ctl, fy_ctl, dx_ctl, dy_ctl;
	logic [SW-1:0]  mag_x, mag_y, mag_w;
	logic [31:0]    qx, qy;
	logic           out_vld_q, out_ok_q;
	logic [63:0]    out_data_q;
	logic           both_ok;

	// Advance the whole pipeline unless the output word is held
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= ONE_Q;
			row_y_q  <= ONE_Q << 32;
			row_w_q  <= '0;
			offs_x_q <= '0;
			offs_y_q <= '0;
			offs_w_q <= ONE_Q[31:0];
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW_X:  row_x_q  <= cfg_data;
				CFG_ROW_Y:  row_y_q  <= cfg_data;
				CFG_ROW_W:  row_w_q  <= cfg_data;
				CFG_OFFS_X: offs_x_q <= cfg_data[31:0];
				CFG_OFFS_Y: offs_y_q <= cfg_data[31:0];
				CFG_OFFS_W: offs_w_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	phm_front #(
		.PIXEL_BITS(PIXEL_BITS),
		.FRAC_BITS (FRAC_BITS),
		.SW        (SW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(s_axis_tvalid),
		.pixel_u (s_axis_tdata[PIXEL_BITS-1:0]),
		.pixel_v (s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
		.row_x   (row_x_q),
		.row_y   (row_y_q),
		.row_w   (row_w_q),
		.offs_x  (offs_x_q),
		.offs_y  (offs_y_q),
		.offs_w  (offs_w_q),
		.ctl_x   (fx_ctl),
		.ctl_y   (fy_ctl),
		.mag_x   (mag_x),
		.mag_y   (mag_y),
		.mag_w   (mag_w)
	);

	phm_div #(.SW(SW)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (fx_ctl),
		.num    (mag_x),
		.den    (mag_w),
		.ctl_out(dx_ctl),
		.quot   (qx)
	);

	phm_div #(.SW(SW)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (fy_ctl),
		.num    (mag_y),
		.den    (mag_w),
		.ctl_out(dy_ctl),
		.quot   (qy)
	);

	assign both_ok = dx_ctl.ok && dy_ctl.ok;

	// Output register: zero both coordinates when either quotient failed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dx_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ok_q   <= both_ok;
			out_data_q <= both_ok ? {qy, qx} : 64'd0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ok_q;

	// Both divider lanes carry the same item
	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		dx_ctl.valid == dy_ctl.valid)
		else $error("divider lanes out of step");

	// An invalid point comes out as zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
		else $error("invalid point with nonzero data");

	// Input is taken exactly when the pipeline advances
	a_ready_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

endmodule
`default_nettype wire

>>> rtl/phm_front.sv
// Front end: products, homogeneous sums, magnitudes and denominator check.
`default_nettype none
module phm_front #(
	parameter int PIXEL_BITS = phm_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = phm_pkg::FRAC_BITS_DEF,
	parameter int SW         = phm_pkg::sum_width(PIXEL_BITS, FRAC_BITS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire logic [PIXEL_BITS-1:0] pixel_u,
	input  wire logic [PIXEL_BITS-1:0] pixel_v,
	input  wire logic [63:0]           row_x,
	input  wire logic [63:0]           row_y,
	input  wire logic [63:0]           row_w,
	input  wire logic [31:0]           offs_x,
	input  wire logic [31:0]           offs_y,
	input  wire logic [31:0]           offs_w,
	output phm_pkg::phm_ctl_t          ctl_x,
	output phm_pkg::phm_ctl_t          ctl_y,
	output logic [SW-1:0]              mag_x,
	output logic [SW-1:0]              mag_y,
	output logic [SW-1:0]              mag_w
);
	import phm_pkg::*;

	localparam int PW = 33 + PIXEL_BITS;
	localparam int SH = PROJ_FRAC - FRAC_BITS;

	logic signed [PIXEL_BITS:0] u_ext, v_ext;
	logic signed [PW-1:0] p0_s1, p1_s1, p3_s1, p4_s1, p6_s1, p7_s1;
	logic signed [SW-1:0] xh_s2, yh_s2, wh_s2;
	logic                 vld_s1, vld_s2, vld_s3;
	logic                 ok_s3, negx_s3, negy_s3;
	logic [SW-1:0]        magx_s3, magy_s3, magw_s3;
	logic [SW-1:0]        abs_w;

	assign u_ext = $signed({1'b0, pixel_u});
	assign v_ext = $signed({1'b0, pixel_v});
	assign abs_w = wh_s2[SW-1] ? SW'(-wh_s2) : SW'(wh_s2);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: six coefficient products
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= $signed(row_x[31:0])  * u_ext;
			p1_s1 <= $signed(row_x[63:32]) * v_ext;
			p3_s1 <= $signed(row_y[31:0])  * u_ext;
			p4_s1 <= $signed(row_y[63:32]) * v_ext;
			p6_s1 <= $signed(row_w[31:0])  * u_ext;
			p7_s1 <= $signed(row_w[63:32]) * v_ext;
		end
	end

	// Stage 2: homogeneous sums, offset of w scaled to the projective format
	always_ff @(posedge clk) begin
		if (en) begin
			xh_s2 <= SW'(p0_s1) + SW'(p1_s1) + SW'($signed(offs_x));
			yh_s2 <= SW'(p3_s1) + SW'(p4_s1) + SW'($signed(offs_y));
			wh_s2 <= SW'(p6_s1) + SW'(p7_s1) + (SW'($signed(offs_w)) <<< SH);
		end
	end

	// Stage 3: magnitudes, quotient signs, small denominator check
	always_ff @(posedge clk) begin
		if (en) begin
			magx_s3 <= xh_s2[SW-1] ? SW'(-xh_s2) : SW'(xh_s2);
			magy_s3 <= yh_s2[SW-1] ? SW'(-yh_s2) : SW'(yh_s2);
			magw_s3 <= abs_w;
			negx_s3 <= xh_s2[SW-1] ^ wh_s2[SW-1];
			negy_s3 <= yh_s2[SW-1] ^ wh_s2[SW-1];
			ok_s3   <= abs_w > SW'(W_EPS_Q30);
		end
	end

	assign ctl_x = '{valid: vld_s3, ok: ok_s3, neg: negx_s3};
	assign ctl_y = '{valid: vld_s3, ok: ok_s3, neg: negy_s3};
	assign mag_x = magx_s3;
	assign mag_y = magy_s3;
	assign mag_w = magw_s3;

endmodule
`default_nettype wire

>>> rtl/phm_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed 32-bit result.
`default_nettype none
module phm_div #(
	parameter int SW = 51
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire phm_pkg::phm_ctl_t ctl_in,
	input  wire logic [SW-1:0]     num,
	input  wire logic [SW-1:0]     den,
	output phm_pkg::phm_ctl_t      ctl_out,
	output logic [31:0]            quot
);
	import phm_pkg::*;

	localparam int NS = QUOT_BITS;

	phm_ctl_t               ctl_s [0:NS];
	logic [SW-1:0]          rem_s [0:NS];
	logic [SW-1:0]          den_s [0:NS];
	logic [2:0]             nlo_s [0:NS];
	logic [QUOT_BITS-1:0]   q_s   [0:NS];
	phm_ctl_t               ctl_f_s;
	logic [31:0]            quot_f_s;
	logic                   fits;
	logic [QUOT_BITS-1:0]   qf;

	// Entry: quotient stays below 2^33 only if num < 8*den; seed remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= '{valid: ctl_in.valid,
			              ok:    ctl_in.ok && ({3'b000, num} < {den, 3'b000}),
			              neg:   ctl_in.neg};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num >> 3;
			den_s[0] <= den;
			nlo_s[0] <= num[2:0];
			q_s[0]   <= '0;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar j = 0; j < NS; j++) begin : g_step
		logic          bit_in;
		logic [SW:0]   trial;
		logic          ge;

		if (j < 3) begin : g_lo
			assign bit_in = nlo_s[j][2-j];
		end else begin : g_zero
			assign bit_in = 1'b0;
		end

		assign trial = {rem_s[j], bit_in};
		assign ge    = trial >= {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? SW'(trial - {1'b0, den_s[j]}) : SW'(trial);
				den_s[j+1] <= den_s[j];
				nlo_s[j+1] <= nlo_s[j];
				q_s[j+1]   <= {q_s[j][QUOT_BITS-2:0], ge};
			end
		end
	end

	// Final: apply sign, check signed 32-bit range, clear ok when it does not fit
	assign qf   = q_s[NS];
	assign fits = ctl_s[NS].neg ? (qf <= QUOT_BITS'(33'h080000000))
	                            : (qf <= QUOT_BITS'(33'h07FFFFFFF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_f_s <= '0;
		end else if (en) begin
			ctl_f_s <= '{valid: ctl_s[NS].valid,
			             ok:    ctl_s[NS].ok && fits,
			             neg:   ctl_s[NS].neg};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_f_s <= ctl_s[NS].neg ? 32'(-qf) : qf[31:0];
		end
	end

	assign ctl_out = ctl_f_s;
	assign quot    = quot_f_s;

endmodule
`default_nettype wire
